// ===== design/cts_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cts_pkg - shared types and constants for the Cartesian to spherical converter
// Working widths, the CORDIC arctangent table in degrees and the output limits.
// ----------------------------------------------------------------------------
package cts_pkg;

    // Working width of the CORDIC datapath; inputs are scaled to about 2^39
    localparam int WORK_BITS   = 44;
    // Angle accumulator: degrees with 16 fraction bits
    localparam int ANGLE_BITS  = 27;
    localparam int TAB_LEN     = 24;

    // Gain correction: multiply by 1/K in Q20, split into two partial products
    localparam int GAIN_SHIFT  = 20;
    localparam int GAIN_BITS   = 20;
    localparam int PROD_SPLIT  = 22;
    localparam int PART_BITS   = PROD_SPLIT + GAIN_BITS;
    localparam int SUM_BITS    = 66;

    // Output angle rounding from 16 to 7 fraction bits
    localparam int ANGLE_SHIFT  = 9;
    localparam int ANGLE_Q_BITS = ANGLE_BITS - ANGLE_SHIFT;
    localparam int RADIUS_BITS  = 16;

    typedef logic signed [WORK_BITS-1:0]    t_work;
    typedef logic signed [ANGLE_BITS-1:0]   t_angle;
    typedef logic [PART_BITS-1:0]           t_part;
    typedef logic [SUM_BITS-1:0]            t_sum;
    typedef logic signed [ANGLE_Q_BITS-1:0] t_angle_q;

    localparam logic [GAIN_BITS-1:0] INV_GAIN_Q20 = 20'd636751;

    localparam t_angle HALF_TURN   = 27'sd11796480;
    localparam t_angle ANGLE_ROUND = 27'sd256;

    localparam t_angle_q YAW_LIMIT   = 18'sd23040;
    localparam t_angle_q PITCH_LIMIT = 18'sd11520;

    // atan(2^-i) in degrees, 16 fraction bits
    localparam t_angle ATAN_DEG_TAB [TAB_LEN] = '{
        27'sd2949120, 27'sd1740967, 27'sd919879, 27'sd466945,
        27'sd234379,  27'sd117304,  27'sd58666,  27'sd29335,
        27'sd14668,   27'sd7334,    27'sd3667,   27'sd1833,
        27'sd917,     27'sd458,     27'sd229,    27'sd115,
        27'sd57,      27'sd29,      27'sd14,     27'sd7,
        27'sd4,       27'sd2,       27'sd1,      27'sd0
    };

endpackage

// ===== design/cartesian_to_spherical_top.sv =====
`timescale 1ns / 1ps
// o_valid follows an accepted item through the yaw pass stages, the first gain
// multiply register, the pitch pass stages, the second gain multiply register and
// the output register. Throughput: one item every cycle; busy is low outside reset,
// since both unrolled CORDIC passes and the gain multipliers are fully pipelined.
// Reset (synchronous, active low) clears every valid bit and holds busy high while
// it is asserted and until the first clock edge after its release.
// ----------------------------------------------------------------------------
// cartesian_to_spherical_top - 3D point to radius, yaw and pitch
// Two pipelined CORDIC vectoring passes with pipelined gain correction.
// ----------------------------------------------------------------------------
module cartesian_to_spherical_top #(
    parameter int COORD_BITS    = 16,
    parameter int CORDIC_STAGES = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic signed [COORD_BITS-1:0]   i_x_coord,
    input  logic signed [COORD_BITS-1:0]   i_y_coord,
    input  logic signed [COORD_BITS-1:0]   i_z_coord,
    output logic                           o_valid,
    output logic [15:0]                    o_radius,
    output logic signed [15:0]             o_yaw_angle,
    output logic signed [14:0]             o_pitch_angle
);

    localparam int WORK_FRAC = 40 - COORD_BITS;
    localparam int RAD_SHIFT = cts_pkg::GAIN_SHIFT + WORK_FRAC;
    localparam int NS        = CORDIC_STAGES;
    localparam int MSB       = cts_pkg::WORK_BITS - 1;

    localparam cts_pkg::t_sum HC_ROUND  = cts_pkg::t_sum'(1) << (cts_pkg::GAIN_SHIFT - 1);
    localparam cts_pkg::t_sum RAD_ROUND = cts_pkg::t_sum'(1) << (RAD_SHIFT - 1);
    localparam cts_pkg::t_sum RAD_MAX   = cts_pkg::t_sum'(65535);

    // Round degrees*2^16 to 7 fraction bits and clamp to +-limit
    function automatic cts_pkg::t_angle_q angle_q(input cts_pkg::t_angle a,
                                                  input cts_pkg::t_angle_q lim);
        cts_pkg::t_angle   t;
        cts_pkg::t_angle_q q;
        t = (a + cts_pkg::ANGLE_ROUND) >>> cts_pkg::ANGLE_SHIFT;
        q = t[cts_pkg::ANGLE_Q_BITS-1:0];
        if (q > lim) begin
            q = lim;
        end else if (q < -lim) begin
            q = -lim;
        end
        return q;
    endfunction

    logic accept;
    logic r_busy;

    // Yaw pass: stage 0 is the input register
    logic             r_y1_vld [0:NS];
    cts_pkg::t_work   r_y1_x   [0:NS];
    cts_pkg::t_work   r_y1_y   [0:NS];
    cts_pkg::t_work   r_y1_z   [0:NS];
    cts_pkg::t_angle  r_y1_ang [0:NS];
    logic             r_y1_nz  [0:NS];

    // First gain multiply
    logic             r_m1_vld;
    cts_pkg::t_part   r_m1_pl;
    cts_pkg::t_part   r_m1_ph;
    cts_pkg::t_angle  r_m1_yaw;
    cts_pkg::t_work   r_m1_z;

    // Pitch pass: stage 0 holds the corrected horizontal length
    logic             r_p2_vld [0:NS];
    cts_pkg::t_work   r_p2_x   [0:NS];
    cts_pkg::t_work   r_p2_y   [0:NS];
    cts_pkg::t_angle  r_p2_ang [0:NS];
    cts_pkg::t_angle  r_p2_yaw [0:NS];
    logic             r_p2_nz  [0:NS];

    // Second gain multiply
    logic             r_m3_vld;
    cts_pkg::t_part   r_m3_pl;
    cts_pkg::t_part   r_m3_ph;
    cts_pkg::t_angle  r_m3_yaw;
    cts_pkg::t_angle  r_m3_pitch;

    // Output registers
    logic                      r_o_vld;
    logic [15:0]               r_o_radius;
    logic signed [15:0]        r_o_yaw;
    logic signed [14:0]        r_o_pitch;

    cts_pkg::t_work   n_x;
    cts_pkg::t_work   n_y;
    cts_pkg::t_work   n_z;
    cts_pkg::t_work   n_x0;
    cts_pkg::t_work   n_y0;
    cts_pkg::t_angle  n_base;
    logic             n_nz;

    cts_pkg::t_work   n_h_pos;
    cts_pkg::t_part   n_m1_pl;
    cts_pkg::t_part   n_m1_ph;
    cts_pkg::t_angle  n_m1_yaw;

    cts_pkg::t_sum    n_m2_sum;
    cts_pkg::t_work   n_hc;
    logic             n_m2_nz;

    cts_pkg::t_work   n_len_pos;
    cts_pkg::t_part   n_m3_pl;
    cts_pkg::t_part   n_m3_ph;
    cts_pkg::t_angle  n_m3_pitch;

    cts_pkg::t_sum    n_o_sum;
    cts_pkg::t_sum    n_o_full;
    logic [15:0]      n_o_radius;
    cts_pkg::t_angle_q n_o_yaw_q;
    cts_pkg::t_angle_q n_o_pitch_q;

    // Hold busy through reset and until the first edge after its release
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    assign busy   = r_busy | ~i_rst_n;
    assign accept = start & ~busy;

    // Scale inputs, turn the left half plane by 180 degrees
    always_comb begin
        n_x    = cts_pkg::t_work'(i_x_coord) <<< WORK_FRAC;
        n_y    = cts_pkg::t_work'(i_y_coord) <<< WORK_FRAC;
        n_z    = cts_pkg::t_work'(i_z_coord) <<< WORK_FRAC;
        n_nz   = (i_x_coord != '0) || (i_y_coord != '0);
        n_x0   = n_x;
        n_y0   = n_y;
        n_base = '0;
        if (n_x[MSB]) begin
            n_x0   = -n_x;
            n_y0   = -n_y;
            n_base = n_y[MSB] ? -cts_pkg::HALF_TURN : cts_pkg::HALF_TURN;
        end
    end

    // Advance valid bits of the yaw pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= NS; s++) begin
                r_y1_vld[s] <= 1'b0;
            end
        end else begin
            r_y1_vld[0] <= accept;
            for (int s = 0; s < NS; s++) begin
                r_y1_vld[s+1] <= r_y1_vld[s];
            end
        end
    end

    // Yaw pass datapath: one vectoring iteration per stage
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_y1_x[0]   <= n_x0;
            r_y1_y[0]   <= n_y0;
            r_y1_z[0]   <= n_z;
            r_y1_ang[0] <= n_base;
            r_y1_nz[0]  <= n_nz;
        end
        for (int s = 0; s < NS; s++) begin
            if (r_y1_vld[s]) begin
                if (r_y1_y[s][MSB]) begin
                    r_y1_x[s+1]   <= r_y1_x[s] - (r_y1_y[s] >>> s);
                    r_y1_y[s+1]   <= r_y1_y[s] + (r_y1_x[s] >>> s);
                    r_y1_ang[s+1] <= r_y1_ang[s] - cts_pkg::ATAN_DEG_TAB[s];
                end else begin
                    r_y1_x[s+1]   <= r_y1_x[s] + (r_y1_y[s] >>> s);
                    r_y1_y[s+1]   <= r_y1_y[s] - (r_y1_x[s] >>> s);
                    r_y1_ang[s+1] <= r_y1_ang[s] + cts_pkg::ATAN_DEG_TAB[s];
                end
                r_y1_z[s+1]  <= r_y1_z[s];
                r_y1_nz[s+1] <= r_y1_nz[s];
            end
        end
    end

    // Split the horizontal length into two partial products with 1/K
    always_comb begin
        n_h_pos  = r_y1_x[NS][MSB] ? '0 : r_y1_x[NS];
        n_m1_pl  = cts_pkg::t_part'(n_h_pos[cts_pkg::PROD_SPLIT-1:0])
                 * cts_pkg::t_part'(cts_pkg::INV_GAIN_Q20);
        n_m1_ph  = cts_pkg::t_part'(n_h_pos[MSB:cts_pkg::PROD_SPLIT])
                 * cts_pkg::t_part'(cts_pkg::INV_GAIN_Q20);
        n_m1_yaw = r_y1_nz[NS] ? r_y1_ang[NS] : '0;
    end

    // Combine partial products and round to the corrected length
    always_comb begin
        n_m2_sum = (cts_pkg::t_sum'(r_m1_ph) << cts_pkg::PROD_SPLIT)
                 + cts_pkg::t_sum'(r_m1_pl) + HC_ROUND;
        n_hc     = n_m2_sum[cts_pkg::GAIN_SHIFT +: cts_pkg::WORK_BITS];
        n_m2_nz  = (n_hc != '0) || (r_m1_z != '0);
    end

    // Advance valid bits through the multiply and the pitch pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1_vld <= 1'b0;
            for (int s = 0; s <= NS; s++) begin
                r_p2_vld[s] <= 1'b0;
            end
            r_m3_vld <= 1'b0;
            r_o_vld  <= 1'b0;
        end else begin
            r_m1_vld    <= r_y1_vld[NS];
            r_p2_vld[0] <= r_m1_vld;
            for (int s = 0; s < NS; s++) begin
                r_p2_vld[s+1] <= r_p2_vld[s];
            end
            r_m3_vld <= r_p2_vld[NS];
            r_o_vld  <= r_m3_vld;
        end
    end

    // First gain multiply registers
    always_ff @(posedge i_clk) begin
        if (r_y1_vld[NS]) begin
            r_m1_pl  <= n_m1_pl;
            r_m1_ph  <= n_m1_ph;
            r_m1_yaw <= n_m1_yaw;
            r_m1_z   <= r_y1_z[NS];
        end
    end

    // Pitch pass datapath: vector (h, z) toward the h axis
    always_ff @(posedge i_clk) begin
        if (r_m1_vld) begin
            r_p2_x[0]   <= n_hc;
            r_p2_y[0]   <= r_m1_z;
            r_p2_ang[0] <= '0;
            r_p2_yaw[0] <= r_m1_yaw;
            r_p2_nz[0]  <= n_m2_nz;
        end
        for (int s = 0; s < NS; s++) begin
            if (r_p2_vld[s]) begin
                if (r_p2_y[s][MSB]) begin
                    r_p2_x[s+1]   <= r_p2_x[s] - (r_p2_y[s] >>> s);
                    r_p2_y[s+1]   <= r_p2_y[s] + (r_p2_x[s] >>> s);
                    r_p2_ang[s+1] <= r_p2_ang[s] - cts_pkg::ATAN_DEG_TAB[s];
                end else begin
                    r_p2_x[s+1]   <= r_p2_x[s] + (r_p2_y[s] >>> s);
                    r_p2_y[s+1]   <= r_p2_y[s] - (r_p2_x[s] >>> s);
                    r_p2_ang[s+1] <= r_p2_ang[s] + cts_pkg::ATAN_DEG_TAB[s];
                end
                r_p2_yaw[s+1] <= r_p2_yaw[s];
                r_p2_nz[s+1]  <= r_p2_nz[s];
            end
        end
    end

    // Partial products of the full length with 1/K
    always_comb begin
        n_len_pos  = r_p2_x[NS][MSB] ? '0 : r_p2_x[NS];
        n_m3_pl    = cts_pkg::t_part'(n_len_pos[cts_pkg::PROD_SPLIT-1:0])
                   * cts_pkg::t_part'(cts_pkg::INV_GAIN_Q20);
        n_m3_ph    = cts_pkg::t_part'(n_len_pos[MSB:cts_pkg::PROD_SPLIT])
                   * cts_pkg::t_part'(cts_pkg::INV_GAIN_Q20);
        n_m3_pitch = r_p2_nz[NS] ? r_p2_ang[NS] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (r_p2_vld[NS]) begin
            r_m3_pl    <= n_m3_pl;
            r_m3_ph    <= n_m3_ph;
            r_m3_yaw   <= r_p2_yaw[NS];
            r_m3_pitch <= n_m3_pitch;
        end
    end

    // Round and saturate the radius, round and clamp both angles
    always_comb begin
        n_o_sum  = (cts_pkg::t_sum'(r_m3_ph) << cts_pkg::PROD_SPLIT)
                 + cts_pkg::t_sum'(r_m3_pl) + RAD_ROUND;
        n_o_full = n_o_sum >> RAD_SHIFT;
        if (n_o_full > RAD_MAX) begin
            n_o_radius = 16'hFFFF;
        end else begin
            n_o_radius = n_o_full[cts_pkg::RADIUS_BITS-1:0];
        end
        n_o_yaw_q   = angle_q(r_m3_yaw, cts_pkg::YAW_LIMIT);
        n_o_pitch_q = angle_q(r_m3_pitch, cts_pkg::PITCH_LIMIT);
    end

    always_ff @(posedge i_clk) begin
        if (r_m3_vld) begin
            r_o_radius <= n_o_radius;
            r_o_yaw    <= n_o_yaw_q[15:0];
            r_o_pitch  <= n_o_pitch_q[14:0];
        end
    end

    assign o_valid       = r_o_vld;
    assign o_radius      = r_o_radius;
    assign o_yaw_angle   = r_o_yaw;
    assign o_pitch_angle = r_o_pitch;

endmodule

// ===== design/cts_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cts_checker - port-level checks for the Cartesian to spherical converter
// Fixed latency between accepted item and strobe, and output angle ranges.
// ----------------------------------------------------------------------------
module cts_checker #(
    parameter int LATENCY = 37
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic               o_valid,
    input logic signed [15:0] o_yaw_angle,
    input logic signed [14:0] o_pitch_angle
);

    // Every accepted item yields a strobe after the pipeline latency
    a_item_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LATENCY o_valid)
        else $error("accepted item produced no result");

    // Every strobe comes from an accepted item
    a_no_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, LATENCY))
        else $error("result without an accepted item");

    // Yaw stays inside +-180 degrees
    a_yaw_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_yaw_angle <= 16'sd23040) && (o_yaw_angle >= -16'sd23040))
        else $error("yaw out of range");

    // Pitch stays inside +-90 degrees
    a_pitch_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_pitch_angle <= 15'sd11520) && (o_pitch_angle >= -15'sd11520))
        else $error("pitch out of range");

endmodule

bind cartesian_to_spherical_top cts_checker #(
    .LATENCY (2 * CORDIC_STAGES + 5)
) u_cts_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .o_valid       (o_valid),
    .o_yaw_angle   (o_yaw_angle),
    .o_pitch_angle (o_pitch_angle)
);

// ===== sim/spherical_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spherical_checker - result checker for the Cartesian to spherical converter
// Watches the command and result ports. For every accepted point it computes
// radius, yaw and pitch with its own fixed-point CORDIC model and queues the
// result. Each strobed result is compared field by field with the oldest one.
// ----------------------------------------------------------------------------
module spherical_checker #(
    parameter int COORD_BITS    = 16,
    parameter int CORDIC_STAGES = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic                         i_busy,
    input  logic signed [COORD_BITS-1:0] i_x_coord,
    input  logic signed [COORD_BITS-1:0] i_y_coord,
    input  logic signed [COORD_BITS-1:0] i_z_coord,
    input  logic                         i_valid,
    input  logic [15:0]                  i_radius,
    input  logic signed [15:0]           i_yaw_angle,
    input  logic signed [14:0]           i_pitch_angle,
    output int                           o_mismatches,
    output int                           o_pending,
    output int                           o_checked
);

    localparam int    WORK_FRAC    = 40 - COORD_BITS;
    localparam int    ATAN_LEN     = 24;
    localparam longint INV_GAIN    = 636751;
    localparam longint HALF_TURN   = 64'sd180 <<< 16;
    localparam longint YAW_LIMIT   = 23040;
    localparam longint PITCH_LIMIT = 11520;
    localparam int    REPORT_MAX   = 10;

    // atan(2^-i) in degrees, 16 fraction bits
    localparam longint ATAN_DEG [ATAN_LEN] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    typedef struct packed {
        logic [15:0]        radius;
        logic signed [15:0] yaw;
        logic signed [14:0] pitch;
    } t_spherical;

    t_spherical expected_points [$];

    // Rotate (px, py) onto the positive x axis; return the angle turned through
    function automatic longint vector_rotate(inout longint px, inout longint py);
        longint dx;
        longint dy;
        longint turned;
        turned = 0;
        for (int i = 0; i < CORDIC_STAGES && i < ATAN_LEN; i++) begin
            dx = py >>> i;
            dy = px >>> i;
            if (py < 0) begin
                px = px - dx;
                py = py + dy;
                turned = turned - ATAN_DEG[i];
            end else begin
                px = px + dx;
                py = py - dy;
                turned = turned + ATAN_DEG[i];
            end
        end
        return turned;
    endfunction

    // Multiply by 1/K in Q20 and drop extra fraction bits, rounding half up
    function automatic longint unscale_gain(longint v, int extra);
        int sh;
        sh = 20 + extra;
        if (v < 0) begin
            v = 0;
        end
        return (v * INV_GAIN + (64'sd1 <<< (sh - 1))) >>> sh;
    endfunction

    // Round degrees from 16 to 7 fraction bits and clamp
    function automatic longint quantize_angle(longint a, longint lim);
        longint q;
        q = (a + 256) >>> 9;
        if (q > lim) begin
            q = lim;
        end
        if (q < -lim) begin
            q = -lim;
        end
        return q;
    endfunction

    function automatic t_spherical spherical_of(logic signed [COORD_BITS-1:0] xc,
                                                logic signed [COORD_BITS-1:0] yc,
                                                logic signed [COORD_BITS-1:0] zc);
        longint x;
        longint y;
        longint z;
        longint yaw;
        longint pitch;
        longint h;
        longint hc;
        longint r;
        longint len;
        longint zz;
        longint base;
        t_spherical res;
        x = longint'(xc) * (64'sd1 <<< WORK_FRAC);
        y = longint'(yc) * (64'sd1 <<< WORK_FRAC);
        z = longint'(zc) * (64'sd1 <<< WORK_FRAC);
        yaw = 0;
        pitch = 0;
        h = 0;
        r = 0;
        // Horizontal pass; turn the left half plane by a half turn first
        if (x != 0 || y != 0) begin
            base = 0;
            if (x < 0) begin
                base = (y >= 0) ? HALF_TURN : -HALF_TURN;
                x = -x;
                y = -y;
            end
            yaw = base + vector_rotate(x, y);
            h = x;
        end
        hc = unscale_gain(h, 0);
        // Elevation pass on (horizontal length, z)
        if (hc != 0 || z != 0) begin
            len = hc;
            zz = z;
            pitch = vector_rotate(len, zz);
            r = unscale_gain(len, WORK_FRAC);
            if (r > 65535) begin
                r = 65535;
            end
        end
        res.radius = r[15:0];
        res.yaw    = 16'(quantize_angle(yaw, YAW_LIMIT));
        res.pitch  = 15'(quantize_angle(pitch, PITCH_LIMIT));
        return res;
    endfunction

    initial begin
        o_mismatches = 0;
        o_pending    = 0;
        o_checked    = 0;
    end

    // Check strobed results first, then queue the point taken at this edge
    always @(posedge i_clk) begin
        t_spherical want;
        if (i_rst_n === 1'b1 && i_valid === 1'b1) begin
            if (expected_points.size() == 0) begin
                if (o_mismatches < REPORT_MAX) begin
                    $display("[%0t] unexpected result: radius %0d yaw %0d pitch %0d",
                             $realtime, i_radius, i_yaw_angle, i_pitch_angle);
                end
                o_mismatches <= o_mismatches + 1;
            end else begin
                want = expected_points.pop_front();
                o_checked <= o_checked + 1;
                if (i_radius !== want.radius || i_yaw_angle !== want.yaw
                        || i_pitch_angle !== want.pitch) begin
                    if (o_mismatches < REPORT_MAX) begin
                        $display({"[%0t] mismatch: expected r %0d yaw %0d pitch %0d,",
                                  " got r %0d yaw %0d pitch %0d"},
                                 $realtime, want.radius, want.yaw, want.pitch,
                                 i_radius, i_yaw_angle, i_pitch_angle);
                    end
                    o_mismatches <= o_mismatches + 1;
                end
            end
        end
        if (i_rst_n === 1'b1 && i_start === 1'b1 && i_busy === 1'b0) begin
            expected_points.push_back(spherical_of(i_x_coord, i_y_coord, i_z_coord));
        end
        o_pending <= expected_points.size();
    end

endmodule

// ===== sim/tb_cartesian_to_spherical_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cartesian_to_spherical_top - testbench for the Cartesian to spherical top
// Drives directed corner points and then random points with random idle
// cycles; the checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_cartesian_to_spherical_top;

    localparam int COORD_BITS    = 16;
    localparam int CORDIC_STAGES = 16;
    localparam int LATENCY       = 2 * CORDIC_STAGES + 5;
    localparam int RANDOM_POINTS = 600;
    localparam int CYCLE_LIMIT   = 200000;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         start;
    logic                         busy;
    logic signed [COORD_BITS-1:0] i_x_coord;
    logic signed [COORD_BITS-1:0] i_y_coord;
    logic signed [COORD_BITS-1:0] i_z_coord;
    logic                         o_valid;
    logic [15:0]                  o_radius;
    logic signed [15:0]           o_yaw_angle;
    logic signed [14:0]           o_pitch_angle;

    int mismatches;
    int pending;
    int checked;
    int points_sent;
    int directed_sent;
    int cycle_count;
    bit idle_enable;

    cartesian_to_spherical_top #(
        .COORD_BITS   (COORD_BITS),
        .CORDIC_STAGES(CORDIC_STAGES)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_x_coord    (i_x_coord),
        .i_y_coord    (i_y_coord),
        .i_z_coord    (i_z_coord),
        .o_valid      (o_valid),
        .o_radius     (o_radius),
        .o_yaw_angle  (o_yaw_angle),
        .o_pitch_angle(o_pitch_angle)
    );

    spherical_checker #(
        .COORD_BITS   (COORD_BITS),
        .CORDIC_STAGES(CORDIC_STAGES)
    ) i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_x_coord    (i_x_coord),
        .i_y_coord    (i_y_coord),
        .i_z_coord    (i_z_coord),
        .i_valid      (o_valid),
        .i_radius     (o_radius),
        .i_yaw_angle  (o_yaw_angle),
        .i_pitch_angle(o_pitch_angle),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    // Generate the clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Stop a hung run
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("end of test: mismatches");
        $finish;
    end

    // Offer one point from a falling edge and hold it until taken
    task automatic send_point(logic signed [COORD_BITS-1:0] x,
                              logic signed [COORD_BITS-1:0] y,
                              logic signed [COORD_BITS-1:0] z);
        while (idle_enable && $urandom_range(0, 99) < 25) begin
            start     = 1'b0;
            i_x_coord = COORD_BITS'($urandom);
            i_y_coord = COORD_BITS'($urandom);
            i_z_coord = COORD_BITS'($urandom);
            @(negedge i_clk);
        end
        start     = 1'b1;
        i_x_coord = x;
        i_y_coord = y;
        i_z_coord = z;
        while (busy !== 1'b0) begin
            @(negedge i_clk);
        end
        @(negedge i_clk);
        points_sent++;
    endtask

    // Pick a corner coordinate: an extreme of the range, zero or one step from zero
    function automatic logic signed [COORD_BITS-1:0] edge_coord();
        case ($urandom_range(0, 5))
            0: return -16'sd32768;
            1: return -16'sd32767;
            2: return -16'sd1;
            3: return 16'sd0;
            4: return 16'sd1;
            default: return 16'sd32767;
        endcase
    endfunction

    function automatic logic signed [COORD_BITS-1:0] small_coord();
        return COORD_BITS'($urandom_range(0, 64)) - 16'sd32;
    endfunction

    initial begin
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic signed [COORD_BITS-1:0] z;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_x_coord   = '0;
        i_y_coord   = '0;
        i_z_coord   = '0;
        points_sent = 0;
        idle_enable = 1'b1;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: origin, axes, vertical, left half plane, corners
        send_point(16'sd0, 16'sd0, 16'sd0);
        send_point(16'sd32767, 16'sd0, 16'sd0);
        send_point(-16'sd32768, 16'sd0, 16'sd0);
        send_point(16'sd0, 16'sd32767, 16'sd0);
        send_point(16'sd0, -16'sd32768, 16'sd0);
        send_point(16'sd0, 16'sd0, 16'sd32767);
        send_point(16'sd0, 16'sd0, -16'sd32768);
        send_point(16'sd0, 16'sd0, 16'sd1);
        send_point(16'sd0, 16'sd0, -16'sd1);
        send_point(-16'sd1, 16'sd0, 16'sd0);
        send_point(-16'sd1, 16'sd0, 16'sd5);
        send_point(-16'sd5, -16'sd1, 16'sd0);
        send_point(-16'sd5, 16'sd1, -16'sd3);
        send_point(16'sd1, 16'sd1, 16'sd1);
        send_point(-16'sd1, -16'sd1, -16'sd1);
        send_point(16'sd3, 16'sd4, 16'sd0);
        send_point(-16'sd32768, -16'sd32768, -16'sd32768);
        send_point(16'sd32767, 16'sd32767, 16'sd32767);
        send_point(-16'sd32768, 16'sd32767, -16'sd32768);
        send_point(16'sd32767, -16'sd32768, 16'sd32767);
        send_point(-16'sd32768, -16'sd1, 16'sd32767);
        send_point(16'sd1, 16'sd0, -16'sd32768);
        directed_sent = points_sent;

        // Random: mostly full range, some small, axis, corner and left-half-plane points
        for (int n = 0; n < RANDOM_POINTS; n++) begin
            idle_enable = !(n >= 250 && n < 400);
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: begin
                    x = COORD_BITS'($urandom);
                    y = COORD_BITS'($urandom);
                    z = COORD_BITS'($urandom);
                end
                5, 6: begin
                    x = small_coord();
                    y = small_coord();
                    z = small_coord();
                end
                7: begin
                    x = $urandom_range(0, 1) ? COORD_BITS'($urandom) : '0;
                    y = $urandom_range(0, 1) ? COORD_BITS'($urandom) : '0;
                    z = $urandom_range(0, 1) ? COORD_BITS'($urandom) : '0;
                end
                8: begin
                    x = edge_coord();
                    y = edge_coord();
                    z = edge_coord();
                end
                default: begin
                    x = -COORD_BITS'($urandom_range(1, 32768));
                    y = COORD_BITS'($urandom_range(0, 2)) - 16'sd1;
                    z = COORD_BITS'($urandom);
                end
            endcase
            send_point(x, y, z);
        end
        start = 1'b0;

        // Drain the pipeline, then allow stray strobes to show up
        while (pending != 0) begin
            @(negedge i_clk);
        end
        repeat (LATENCY + 10) @(negedge i_clk);

        $display("Sent %0d points: %0d directed corners, the rest random full-range,",
                 points_sent, directed_sent);
        $display("small, axis-aligned and left-half-plane points; %0d results checked.",
                 checked);
        if (mismatches == 0 && pending == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ===== cartesian_to_spherical_top.f =====
design/cts_pkg.sv
design/cartesian_to_spherical_top.sv
design/cts_checker.sv
sim/spherical_checker.sv
sim/tb_cartesian_to_spherical_top.sv
